// ----- rtl/box_gap_distance_defines.svh -----
// Assertion macros used by the box gap distance RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef BOX_GAP_DISTANCE_DEFINES_SVH
`define BOX_GAP_DISTANCE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BGD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box_gap_distance check failed");

// Next-cycle implication, disabled during reset.
`define BGD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box_gap_distance check failed");

`endif

// ----- rtl/bgd_pkg.sv -----
// Shared types and constants for the box gap distance block.
// No dependencies.
`default_nettype none

package bgd_pkg;

  // Width of the reported distance.
  localparam int GAP_BITS = 25;

  // Sideband that travels with each item down the pipeline.
  typedef struct packed {
    logic valid;
    logic overlap;
  } bgd_tag_t;

endpackage

`default_nettype wire

// ----- rtl/box_gap_distance.sv -----
// Top level of the box gap distance block: axis gaps, squares, sum,
// pipelined square root and saturating output register.
// Depends on bgd_pkg, bgd_isqrt and box_gap_distance_defines.svh.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_ready  a_*/b_* lon/lat min/max corners
//   output   out        out_valid/out_ready  gap_distance, boxes_overlap
//
// One transaction per cycle is accepted while the output side takes results.
// The pipeline has three stages for gaps, squares and sum, one square root
// stage per result bit and one output register.
// A held result with out_ready low freezes every stage; nothing moves or drops.
// rst clears all stage valid bits; no clearing pass is needed.
`default_nettype none

`include "box_gap_distance_defines.svh"

module box_gap_distance #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  a_lon_min,
  input  logic signed [COORD_BITS-1:0]  a_lat_min,
  input  logic signed [COORD_BITS-1:0]  a_lon_max,
  input  logic signed [COORD_BITS-1:0]  a_lat_max,
  input  logic signed [COORD_BITS-1:0]  b_lon_min,
  input  logic signed [COORD_BITS-1:0]  b_lat_min,
  input  logic signed [COORD_BITS-1:0]  b_lon_max,
  input  logic signed [COORD_BITS-1:0]  b_lat_max,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bgd_pkg::GAP_BITS-1:0]  gap_distance,
  output logic                          boxes_overlap
);
  import bgd_pkg::*;

  localparam int CB        = COORD_BITS;
  localparam int ROOT_BITS = CB + 1;

  logic en;

  // Offset binary, so unsigned order matches signed order.
  function automatic logic [CB-1:0] biased(input logic [CB-1:0] v);
    return {~v[CB-1], v[CB-2:0]};
  endfunction

  function automatic logic [CB-1:0] pos_diff(input logic [CB-1:0] p,
                                             input logic [CB-1:0] q);
    logic [CB:0] d;
    d = {1'b0, p} - {1'b0, q};
    return d[CB] ? '0 : d[CB-1:0];
  endfunction

  function automatic logic [CB-1:0] axis_gap(input logic [CB-1:0] a_min,
                                             input logic [CB-1:0] a_max,
                                             input logic [CB-1:0] b_min,
                                             input logic [CB-1:0] b_max);
    logic [CB-1:0] g1;
    logic [CB-1:0] g2;
    g1 = pos_diff(biased(b_min), biased(a_max));
    g2 = pos_diff(biased(a_min), biased(b_max));
    return (g1 > g2) ? g1 : g2;
  endfunction

  // Whole pipeline advances together unless a result sits untaken.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: axis gaps.
  logic          s1_valid;
  logic [CB-1:0] s1_dx;
  logic [CB-1:0] s1_dy;

  // Stage 2: squares.
  bgd_tag_t        s2_tag;
  logic [2*CB-1:0] s2_sx;
  logic [2*CB-1:0] s2_sy;

  // Stage 3: sum of squares.
  bgd_tag_t      s3_tag;
  logic [2*CB:0] s3_sum;

  logic [ROOT_BITS-1:0]  sq_root;
  bgd_tag_t              sq_tag;
  logic [GAP_BITS-1:0]   gap_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_tag    <= '0;
      s3_tag    <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid       <= in_valid;
      s2_tag.valid   <= s1_valid;
      s2_tag.overlap <= (s1_dx == '0) && (s1_dy == '0);
      s3_tag         <= s2_tag;
      out_valid      <= sq_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx         <= axis_gap(a_lon_min, a_lon_max, b_lon_min, b_lon_max);
      s1_dy         <= axis_gap(a_lat_min, a_lat_max, b_lat_min, b_lat_max);
      s2_sx         <= {{CB{1'b0}}, s1_dx} * {{CB{1'b0}}, s1_dx};
      s2_sy         <= {{CB{1'b0}}, s1_dy} * {{CB{1'b0}}, s1_dy};
      s3_sum        <= {1'b0, s2_sx} + {1'b0, s2_sy};
      gap_distance  <= gap_sat;
      boxes_overlap <= sq_tag.overlap;
    end
  end

  bgd_isqrt #(
    .ROOT_BITS (ROOT_BITS)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .radicand ({1'b0, s3_sum}),
    .tag_in   (s3_tag),
    .root_out (sq_root),
    .tag_out  (sq_tag)
  );

  // Clamp the root to the distance width.
  if (ROOT_BITS > GAP_BITS) begin : g_sat
    assign gap_sat = (|sq_root[ROOT_BITS-1:GAP_BITS]) ? '1 : sq_root[GAP_BITS-1:0];
  end else begin : g_ext
    assign gap_sat = GAP_BITS'(sq_root);
  end

  `BGD_ASSERT_NOW(a_overlap_zero, clk, rst, out_valid && boxes_overlap, gap_distance == '0)
  `BGD_ASSERT_NEXT(a_accept_enters, clk, rst, in_valid && in_ready, s1_valid)
  `BGD_ASSERT_NEXT(a_stall_freezes, clk, rst, out_valid && !out_ready, $stable(s3_tag))
  `BGD_ASSERT_NEXT(a_overlap_sum, clk, rst, en && s2_tag.valid && s2_tag.overlap, s3_sum == '0)

endmodule

`default_nettype wire

// ----- rtl/bgd_isqrt.sv -----
// Pipelined floor square root, one result bit per register stage.
// Depends on bgd_pkg for the sideband tag type.
`default_nettype none

module bgd_isqrt #(
  parameter int ROOT_BITS = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [2*ROOT_BITS-1:0]        radicand,
  input  bgd_pkg::bgd_tag_t             tag_in,
  output logic [ROOT_BITS-1:0]          root_out,
  output bgd_pkg::bgd_tag_t             tag_out
);
  import bgd_pkg::*;

  localparam int REM_W = ROOT_BITS + 2;
  localparam int SQ_W  = 2 * ROOT_BITS;

  logic [REM_W-1:0]     rem   [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] root  [0:ROOT_BITS];
  logic [SQ_W-1:0]      sq    [0:ROOT_BITS];
  bgd_tag_t             tag   [0:ROOT_BITS];

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sq[0]   = radicand;
  assign tag[0]  = tag_in;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    localparam int P = 2 * (ROOT_BITS - 1 - k);
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    // Bring down the next bit pair and try the odd-number subtraction.
    assign rem_sh = {rem[k][REM_W-3:0], sq[k][P+1:P]};
    assign trial  = {root[k], 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[k+1] <= '0;
      end else if (en) begin
        tag[k+1] <= tag[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? (rem_sh - trial) : rem_sh;
        root[k+1] <= {root[k][ROOT_BITS-2:0], take};
        sq[k+1]   <= sq[k];
      end
    end
  end

  assign root_out = root[ROOT_BITS];
  assign tag_out  = tag[ROOT_BITS];

endmodule

`default_nettype wire
